[hdl/separable_gaussian_blur_core_assert.svh]
// Assertion macros for the separable blur core.
// Included by the RTL file that carries concurrent checks; needs nothing else.
`ifndef SEPARABLE_GAUSSIAN_BLUR_CORE_ASSERT_SVH
`define SEPARABLE_GAUSSIAN_BLUR_CORE_ASSERT_SVH

// same-cycle implication
`define SGB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/sgb_pkg.sv]
// Shared constants, register indexes and structs of the separable blur core.
// No dependencies.
package sgb_pkg;

   localparam int PIX_W    = 8;
   localparam int CHANNELS = 3;
   localparam int RGB_W    = CHANNELS * PIX_W;
   localparam int PIX_MAX  = 255;

   localparam int WEIGHT_W = 17;
   localparam int FRAC_W   = 16;
   localparam int ACC_W    = 28;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
   localparam int NUM_WEIGHTS = 5;
   localparam int WSEL_W      = 3;

   localparam int COORD_W    = 10;
   localparam int MAX_HEIGHT = 1024;
   localparam int DIM_RESET  = 1024;
   localparam int CFG_DIM_W  = 11;
   localparam int RADIUS_W   = 3;

   localparam int DEF_MAX_RADIUS = 4;
   localparam int DEF_MAX_WIDTH  = 1024;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUR_RADIUS  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_0     = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_1     = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_2     = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_3     = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_4     = 4'd7;

   typedef struct packed {
      logic                valid;
      logic                first;
      logic                last;
      logic [WEIGHT_W-1:0] weight;
      logic [RGB_W-1:0]    pixel;
   } mac_in_type;

   typedef struct packed {
      logic             done;
      logic [RGB_W-1:0] pixel;
   } mac_out_type;

endpackage

[hdl/sgb_cell.sv]
// One pixel cell of the row window chain; takes its neighbor's pixel on a shift.
// Depends on sgb_pkg.
module sgb_cell (
   input  logic                      clock,
   input  logic                      shift_en,
   input  logic [sgb_pkg::RGB_W-1:0] shift_data,
   output logic [sgb_pkg::RGB_W-1:0] pix
);
   import sgb_pkg::*;

   logic [RGB_W-1:0] pix_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pix_ff <= shift_data;
      end
   end

   assign pix = pix_ff;

endmodule

[hdl/sgb_mac.sv]
// Three-channel multiply-accumulate with round-half-up and 8-bit saturation.
// Depends on sgb_pkg.
module sgb_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  sgb_pkg::mac_in_type  mac_in,
   output sgb_pkg::mac_out_type mac_out
);
   import sgb_pkg::*;

   localparam int PROD_W = WEIGHT_W + PIX_W;
   localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1 << (FRAC_W - 1));

   function automatic logic [PIX_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
      logic [ACC_W:0]        sum;
      logic [ACC_W-FRAC_W:0] q;
      sum = {1'b0, acc} + HALF;
      q = sum[ACC_W:FRAC_W];
      round_sat = (q > (ACC_W - FRAC_W + 1)'(PIX_MAX)) ? PIX_W'(PIX_MAX) : q[PIX_W-1:0];
   endfunction

   logic [PROD_W-1:0] prod_ff [CHANNELS];
   logic [PROD_W-1:0] prod_in [CHANNELS];
   logic [ACC_W-1:0]  acc_ff  [CHANNELS];
   logic [ACC_W-1:0]  acc_in  [CHANNELS];
   logic              p_valid_ff;
   logic              p_first_ff;
   logic              p_last_ff;
   logic              done_ff;

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         prod_in[ch] = PROD_W'(mac_in.weight) * PROD_W'(mac_in.pixel[ch*PIX_W +: PIX_W]);
         acc_in[ch]  = p_first_ff ? ACC_W'(prod_ff[ch]) : acc_ff[ch] + ACC_W'(prod_ff[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         p_valid_ff <= mac_in.valid;
         done_ff    <= p_valid_ff && p_last_ff;
      end
      p_first_ff <= mac_in.first;
      p_last_ff  <= mac_in.last;
      prod_ff    <= prod_in;
      if (p_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      mac_out.done = done_ff;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         mac_out.pixel[ch*PIX_W +: PIX_W] = round_sat(acc_ff[ch]);
      end
   end

endmodule

[hdl/separable_gaussian_blur_core.sv]
// Separable Gaussian blur core: pixel window chain, tap sequencer, line store.
// Depends on sgb_pkg, sgb_cell, sgb_mac and separable_gaussian_blur_core_assert.svh.
//
// Usage: pixels enter in raster order on the req_ channel (valid/ready), one
// transfer per pixel. Blurred pixels leave on the rsp_ channel with their
// column and row; rsp_last_of_run marks the final result caused by a pixel.
// A pixel that completes no output column only shifts the window. Otherwise
// each completed column takes a horizontal pass, each result a vertical
// pass, and each column one line store write. All passes run on the single
// shared multiply-accumulate unit, which takes one tap per cycle. Row and
// frame ends release up to (R+1)^2 results. The csr_ channel is always
// ready; width, height or radius writes restart the frame. Reset restores
// W=H=1024, R=0, unit center weight, and restarts the frame; the line store
// needs no clearing. A stalled receiver holds the result register and halts
// the sequencer; the next pixel is taken only once the line store writes
// that follow the previous pixel's results are done.
`include "separable_gaussian_blur_core_assert.svh"
module separable_gaussian_blur_core #(
   parameter int MAX_RADIUS = sgb_pkg::DEF_MAX_RADIUS,
   parameter int MAX_WIDTH  = sgb_pkg::DEF_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sgb_pkg::PIX_W-1:0]       req_red_in,
   input  logic [sgb_pkg::PIX_W-1:0]       req_green_in,
   input  logic [sgb_pkg::PIX_W-1:0]       req_blue_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sgb_pkg::PIX_W-1:0]       rsp_red_out,
   output logic [sgb_pkg::PIX_W-1:0]       rsp_green_out,
   output logic [sgb_pkg::PIX_W-1:0]       rsp_blue_out,
   output logic [sgb_pkg::COORD_W-1:0]     rsp_out_col,
   output logic [sgb_pkg::COORD_W-1:0]     rsp_out_row,
   output logic                            rsp_last_of_run,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sgb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sgb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sgb_pkg::*;

   localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
   localparam int LINES     = 2 * MAX_RADIUS;
   localparam int KW        = $clog2(WIN_DEPTH);
   localparam int SW        = KW + 2;
   localparam int DW        = KW + 1;
   localparam int LW        = $clog2(LINES);
   localparam int IW        = $clog2(MAX_RADIUS + 1);
   localparam int XW        = $clog2(MAX_WIDTH);
   localparam int DEPTH     = LINES * MAX_WIDTH;
   localparam int AW        = $clog2(DEPTH);
   localparam logic [AW-1:0] MW_A = AW'(MAX_WIDTH);
   localparam logic [XW-1:0] LAST_COL_RST =
      XW'(((MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET) - 1);
   localparam logic [COORD_W-1:0] LAST_ROW_RST = COORD_W'(MAX_HEIGHT - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_H_ISSUE,
      ST_H_WAIT,
      ST_V_ISSUE,
      ST_V_WAIT,
      ST_V_OUT,
      ST_WRITE
   } state_type;

   // configuration
   logic [XW-1:0]       last_col_ff, last_col_cfg;
   logic [COORD_W-1:0]  last_row_ff, last_row_cfg;
   logic [IW-1:0]       radius_ff, radius_cfg;
   logic [WEIGHT_W-1:0] weight_ff [NUM_WEIGHTS];
   logic [WEIGHT_W-1:0] weight_cfg;
   logic [CFG_DIM_W-1:0] dim_val;
   logic                csr_fire, geo_write;

   // position
   logic [XW-1:0]      col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [LW-1:0]      line_ff, line_in;
   logic               req_fire, col_end, row_end, col_lt_r, row_lt_r, has_x, has_y;
   logic [IW-1:0]      es_min, fs_min;

   // sequencer
   state_type          state_ff, state_in;
   logic [IW-1:0]      i_ff, i_in, j_ff, j_in;
   logic [KW-1:0]      t_ff, t_in;
   logic [XW-1:0]      cur_col_ff, cur_col_in;
   logic [COORD_W-1:0] cur_row_ff, cur_row_in;
   logic [LW-1:0]      cur_line_ff, cur_line_in;
   logic [IW-1:0]      es_ff, es_in, fs_ff, fs_in;
   logic [IW-1:0]      i_last_ff, i_last_in, j_last_ff, j_last_in;
   logic               rows_ff, rows_in;
   logic [RGB_W-1:0]   hval_ff [MAX_RADIUS + 1];

   // tap generation
   logic [IW-1:0]      e_cur, f_cur, off_sel;
   logic [SW-1:0]      tap_val;
   logic [KW-1:0]      kpos, k_h, k_v, tap_dist;
   logic [DW-1:0]      line_tmp;
   logic [LW-1:0]      line_rd, mem_line;
   logic [XW-1:0]      tap_x;
   logic [COORD_W-1:0] tap_y;
   logic [AW-1:0]      mem_addr;
   logic               mem_we, tap_last;
   logic [WSEL_W-1:0]  w_sel;
   mac_in_type         tap_ff, tap_in, mac_in;
   logic               tap_mem_ff, tap_mem_in;
   logic [RGB_W-1:0]   line_mem [DEPTH];
   logic [RGB_W-1:0]   mem_q_ff;
   mac_out_type        mac_out;

   // window chain
   logic [RGB_W-1:0]   win_pix [WIN_DEPTH];
   logic [RGB_W-1:0]   new_pix;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in, rsp_load, rsp_last_in;
   logic [RGB_W-1:0]       rsp_pix_ff;
   logic [COORD_W-1:0]     rsp_col_ff, rsp_row_ff;
   logic                   rsp_last_ff;
   logic [XW+COORD_W-1:0]  col_wide;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign geo_write = csr_fire && ((csr_index == CSR_IMAGE_WIDTH) ||
                                   (csr_index == CSR_IMAGE_HEIGHT) ||
                                   (csr_index == CSR_BLUR_RADIUS));
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign new_pix   = {req_blue_in, req_green_in, req_red_in};

   for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_win
      if (g == 0) begin : g_head
         sgb_cell u_cell (
            .clock      (clock),
            .shift_en   (req_fire),
            .shift_data (new_pix),
            .pix        (win_pix[g])
         );
      end else begin : g_body
         sgb_cell u_cell (
            .clock      (clock),
            .shift_en   (req_fire),
            .shift_data (win_pix[g-1]),
            .pix        (win_pix[g])
         );
      end
   end

   // register write decode
   always_comb begin
      dim_val = csr_data[CFG_DIM_W-1:0];
      if (dim_val == '0) begin
         last_col_cfg = '0;
         last_row_cfg = '0;
      end else begin
         if (int'(dim_val) > MAX_WIDTH) begin
            last_col_cfg = XW'(MAX_WIDTH - 1);
         end else begin
            last_col_cfg = XW'(dim_val - 1'b1);
         end
         if (int'(dim_val) > MAX_HEIGHT) begin
            last_row_cfg = COORD_W'(MAX_HEIGHT - 1);
         end else begin
            last_row_cfg = COORD_W'(dim_val - 1'b1);
         end
      end
      if (int'(csr_data[RADIUS_W-1:0]) > MAX_RADIUS) begin
         radius_cfg = IW'(MAX_RADIUS);
      end else begin
         radius_cfg = IW'(csr_data[RADIUS_W-1:0]);
      end
      weight_cfg = (csr_data[WEIGHT_W-1:0] > WEIGHT_ONE) ? WEIGHT_ONE
                                                         : csr_data[WEIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= LAST_COL_RST;
         last_row_ff <= LAST_ROW_RST;
         radius_ff   <= '0;
         weight_ff[0] <= WEIGHT_ONE;
         for (int n = 1; n < NUM_WEIGHTS; n++) begin
            weight_ff[n] <= '0;
         end
      end else if (csr_fire) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  last_col_ff  <= last_col_cfg;
            CSR_IMAGE_HEIGHT: last_row_ff  <= last_row_cfg;
            CSR_BLUR_RADIUS:  radius_ff    <= radius_cfg;
            CSR_WEIGHT_0:     weight_ff[0] <= weight_cfg;
            CSR_WEIGHT_1:     weight_ff[1] <= weight_cfg;
            CSR_WEIGHT_2:     weight_ff[2] <= weight_cfg;
            CSR_WEIGHT_3:     weight_ff[3] <= weight_cfg;
            CSR_WEIGHT_4:     weight_ff[4] <= weight_cfg;
            default: ;
         endcase
      end
   end

   // which outputs the incoming pixel completes
   always_comb begin
      col_end  = (col_ff == last_col_ff);
      row_end  = (row_ff == last_row_ff);
      col_lt_r = (col_ff < XW'(radius_ff));
      row_lt_r = (row_ff < COORD_W'(radius_ff));
      es_min   = col_lt_r ? IW'(col_ff) : radius_ff;
      fs_min   = row_lt_r ? IW'(row_ff) : radius_ff;
      has_x    = col_end || !col_lt_r;
      has_y    = row_end || !row_lt_r;

      col_in  = col_ff;
      row_in  = row_ff;
      line_in = line_ff;
      if (geo_write) begin
         col_in  = '0;
         row_in  = '0;
         line_in = '0;
      end else if (req_fire) begin
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               row_in  = '0;
               line_in = '0;
            end else begin
               row_in  = row_ff + 1'b1;
               line_in = (line_ff == LW'(LINES - 1)) ? '0 : line_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         line_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         line_ff <= line_in;
      end
   end

   // tap address generation
   always_comb begin
      e_cur    = es_ff - i_ff;
      f_cur    = fs_ff - j_ff;
      off_sel  = (state_ff == ST_V_ISSUE) ? f_cur : e_cur;
      tap_val  = SW'(off_sel) + SW'(radius_ff) - SW'(t_ff);
      kpos     = tap_val[SW-1] ? '0 : tap_val[KW-1:0];
      k_h      = (cur_col_ff < XW'(kpos)) ? KW'(cur_col_ff) : kpos;
      k_v      = (cur_row_ff < COORD_W'(kpos)) ? KW'(cur_row_ff) : kpos;
      tap_dist = (t_ff >= KW'(radius_ff)) ? t_ff - KW'(radius_ff) : KW'(radius_ff) - t_ff;
      w_sel    = WSEL_W'(tap_dist);
      tap_last = (t_ff == KW'({radius_ff, 1'b0}));
      line_tmp = DW'(cur_line_ff) - DW'(k_v);
      if (line_tmp[DW-1]) begin
         line_tmp = line_tmp + DW'(LINES);
      end
      line_rd  = LW'(line_tmp);
      mem_we   = (state_ff == ST_WRITE);
      mem_line = mem_we ? cur_line_ff : line_rd;
      tap_x    = cur_col_ff - XW'(e_cur);
      tap_y    = cur_row_ff - COORD_W'(f_cur);
      mem_addr = AW'(mem_line) * MW_A + AW'(tap_x);

      tap_in.valid  = (state_ff == ST_H_ISSUE) || (state_ff == ST_V_ISSUE);
      tap_in.first  = (t_ff == '0);
      tap_in.last   = tap_last;
      tap_in.weight = weight_ff[w_sel];
      tap_in.pixel  = (state_ff == ST_H_ISSUE) ? win_pix[k_h] : hval_ff[i_ff];
      tap_mem_in    = (state_ff == ST_V_ISSUE) && (k_v != '0);

      mac_in = tap_ff;
      if (tap_mem_ff) begin
         mac_in.pixel = mem_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in;
      end
      tap_mem_ff <= tap_mem_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_addr] <= hval_ff[i_ff];
      end
      mem_q_ff <= line_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_H_WAIT) && mac_out.done) begin
         hval_ff[i_ff] <= mac_out.pixel;
      end
   end

   sgb_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .mac_in  (mac_in),
      .mac_out (mac_out)
   );

   // sequencer
   always_comb begin
      rsp_load     = (state_ff == ST_V_OUT) && (!rsp_valid_ff || rsp_ready);
      rsp_last_in  = (i_ff == i_last_ff) && (j_ff == j_last_ff);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      col_wide     = {{COORD_W{1'b0}}, tap_x};

      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      t_in        = t_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      cur_line_in = cur_line_ff;
      es_in       = es_ff;
      fs_in       = fs_ff;
      i_last_in   = i_last_ff;
      j_last_in   = j_last_ff;
      rows_in     = rows_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_col_in  = col_ff;
               cur_row_in  = row_ff;
               cur_line_in = line_ff;
               es_in       = col_end ? es_min : radius_ff;
               fs_in       = row_end ? fs_min : radius_ff;
               i_last_in   = col_end ? es_min : '0;
               j_last_in   = row_end ? fs_min : '0;
               rows_in     = has_y;
               i_in        = '0;
               j_in        = '0;
               t_in        = '0;
               if (has_x) begin
                  state_in = ST_H_ISSUE;
               end
            end
         end
         ST_H_ISSUE: begin
            if (tap_last) begin
               t_in     = '0;
               state_in = ST_H_WAIT;
            end else begin
               t_in = t_ff + 1'b1;
            end
         end
         ST_H_WAIT: begin
            if (mac_out.done) begin
               if (i_ff == i_last_ff) begin
                  i_in     = '0;
                  state_in = rows_ff ? ST_V_ISSUE : ST_WRITE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_H_ISSUE;
               end
            end
         end
         ST_V_ISSUE: begin
            if (tap_last) begin
               t_in     = '0;
               state_in = ST_V_WAIT;
            end else begin
               t_in = t_ff + 1'b1;
            end
         end
         ST_V_WAIT: begin
            if (mac_out.done) begin
               state_in = ST_V_OUT;
            end
         end
         ST_V_OUT: begin
            if (rsp_load) begin
               if (i_ff == i_last_ff) begin
                  i_in = '0;
                  if (j_ff == j_last_ff) begin
                     j_in     = '0;
                     state_in = ST_WRITE;
                  end else begin
                     j_in     = j_ff + 1'b1;
                     state_in = ST_V_ISSUE;
                  end
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_V_ISSUE;
               end
            end
         end
         ST_WRITE: begin
            if (i_ff == i_last_ff) begin
               i_in     = '0;
               state_in = ST_IDLE;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         t_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         t_ff         <= t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_col_ff  <= cur_col_in;
      cur_row_ff  <= cur_row_in;
      cur_line_ff <= cur_line_in;
      es_ff       <= es_in;
      fs_ff       <= fs_in;
      i_last_ff   <= i_last_in;
      j_last_ff   <= j_last_in;
      rows_ff     <= rows_in;
      if (rsp_load) begin
         rsp_pix_ff  <= mac_out.pixel;
         rsp_col_ff  <= col_wide[COORD_W-1:0];
         rsp_row_ff  <= tap_y;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_out     = rsp_pix_ff[0*PIX_W +: PIX_W];
   assign rsp_green_out   = rsp_pix_ff[1*PIX_W +: PIX_W];
   assign rsp_blue_out    = rsp_pix_ff[2*PIX_W +: PIX_W];
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `SGB_ASSERT_NOW(a_done_in_wait, clock, reset, mac_out.done, (state_ff == ST_H_WAIT) || (state_ff == ST_V_WAIT), "mac result outside a wait state")
   `SGB_ASSERT_NOW(a_index_range, clock, reset, state_ff != ST_IDLE, (i_ff <= i_last_ff) && (j_ff <= j_last_ff), "output index past its span")
   `SGB_ASSERT_NOW(a_position_range, clock, reset, 1'b1, (col_ff <= last_col_ff) && (row_ff <= last_row_ff), "position counter past frame")
   `SGB_ASSERT_NEXT(a_stall_holds, clock, reset, (state_ff == ST_V_OUT) && rsp_valid_ff && !rsp_ready, state_ff == ST_V_OUT, "result dropped while stalled")

endmodule
